>>> design/prc_pkg.sv
// Shared widths, constants, the arctangent table and the pipeline word for the rotator.
package prc_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int LATENCY       = CORDIC_STAGES + 5;

  localparam int CW        = 32;          // coordinate width
  localparam int AW        = 16;          // angle width
  localparam int ANG_SHIFT = 18;          // Q3.12 to Q.30
  localparam int ZW        = AW + ANG_SHIFT;
  localparam int DW        = CW + 1;      // exact point minus center
  localparam int GUARD     = 16;
  localparam int XW        = 52;          // datapath width with guard bits
  localparam int PW        = 48;          // partial product width
  localparam int SHW       = 5;           // stage index width
  localparam int RW        = XW - GUARD;  // rounded width
  localparam int SW        = RW + 2;      // rounded plus center

  localparam logic signed [ZW-1:0] ANG_PI      = 34'sd3373259426;
  localparam logic signed [ZW-1:0] ANG_HALF_PI = 34'sd1686629713;
  localparam logic signed [ZW-1:0] ANG_TWO_PI  = 34'sd6746518852;
  localparam logic signed [30:0]   GAIN_Q30    = 31'sh26DD3B6A;

  localparam logic [29:0] ATAN_Q30 [32] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6,
    30'h03FEAB76, 30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55,
    30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
    30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF,
    30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
    30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F,
    30'h0000003F, 30'h0000001F, 30'h0000000F, 30'h00000008,
    30'h00000004, 30'h00000002, 30'h00000001, 30'h00000000
  };

  function automatic logic [29:0] atan_q30(input logic [SHW-1:0] idx);
    return ATAN_Q30[idx];
  endfunction

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
  } cordic_t;

endpackage

>>> design/prc_prep.sv
// Front end: center subtraction, angle folding and gain-compensation multiply.
module prc_prep (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            acc,
  input  logic signed [prc_pkg::CW-1:0]   px,
  input  logic signed [prc_pkg::CW-1:0]   py,
  input  logic signed [prc_pkg::CW-1:0]   cx,
  input  logic signed [prc_pkg::CW-1:0]   cy,
  input  logic signed [prc_pkg::AW-1:0]   ang,
  output logic                            q_valid,
  output prc_pkg::cordic_t                q_data
);

  logic signed [prc_pkg::ZW-1:0] z_in;
  logic signed [prc_pkg::ZW-1:0] z_wrap;

  logic                           v1_r, v2_r, v3_r, v4_r;
  logic signed [prc_pkg::DW-1:0]  dx1_r, dy1_r, dx2_r, dy2_r;
  logic signed [prc_pkg::DW-1:0]  dx2_nxt, dy2_nxt;
  logic signed [prc_pkg::ZW-1:0]  z1_r, z2_r, z3_r, z2_nxt;
  logic signed [prc_pkg::CW-1:0]  cx1_r, cy1_r, cx2_r, cy2_r, cx3_r, cy3_r;
  logic signed [prc_pkg::PW-1:0]  phx_r, plx_r, phy_r, ply_r;
  logic signed [63:0]             prod_x, prod_y;
  prc_pkg::cordic_t               d4_r;

  assign z_in = {ang, {prc_pkg::ANG_SHIFT{1'b0}}};

  always_comb begin
    if (z_in > prc_pkg::ANG_PI) begin
      z_wrap = z_in - prc_pkg::ANG_TWO_PI;
    end else if (z_in < -prc_pkg::ANG_PI) begin
      z_wrap = z_in + prc_pkg::ANG_TWO_PI;
    end else begin
      z_wrap = z_in;
    end
  end

  // Angles past a quarter turn are brought back by a half turn, which negates the offset.
  always_comb begin
    if (z1_r > prc_pkg::ANG_HALF_PI) begin
      z2_nxt  = z1_r - prc_pkg::ANG_PI;
      dx2_nxt = -dx1_r;
      dy2_nxt = -dy1_r;
    end else if (z1_r < -prc_pkg::ANG_HALF_PI) begin
      z2_nxt  = z1_r + prc_pkg::ANG_PI;
      dx2_nxt = -dx1_r;
      dy2_nxt = -dy1_r;
    end else begin
      z2_nxt  = z1_r;
      dx2_nxt = dx1_r;
      dy2_nxt = dy1_r;
    end
  end

  assign prod_x = (64'(phx_r) <<< 16) + 64'(plx_r);
  assign prod_y = (64'(phy_r) <<< 16) + 64'(ply_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    dx1_r <= prc_pkg::DW'(px) - prc_pkg::DW'(cx);
    dy1_r <= prc_pkg::DW'(py) - prc_pkg::DW'(cy);
    z1_r  <= z_wrap;
    cx1_r <= cx;
    cy1_r <= cy;

    dx2_r <= dx2_nxt;
    dy2_r <= dy2_nxt;
    z2_r  <= z2_nxt;
    cx2_r <= cx1_r;
    cy2_r <= cy1_r;

    // The 33-bit offset is split into a signed upper and an unsigned lower half.
    phx_r <= prc_pkg::PW'($signed(dx2_r[prc_pkg::DW-1:16])) * prc_pkg::PW'(prc_pkg::GAIN_Q30);
    plx_r <= prc_pkg::PW'($signed({1'b0, dx2_r[15:0]})) * prc_pkg::PW'(prc_pkg::GAIN_Q30);
    phy_r <= prc_pkg::PW'($signed(dy2_r[prc_pkg::DW-1:16])) * prc_pkg::PW'(prc_pkg::GAIN_Q30);
    ply_r <= prc_pkg::PW'($signed({1'b0, dy2_r[15:0]})) * prc_pkg::PW'(prc_pkg::GAIN_Q30);
    z3_r  <= z2_r;
    cx3_r <= cx2_r;
    cy3_r <= cy2_r;

    d4_r.x  <= prc_pkg::XW'($signed(prod_x[63:30-prc_pkg::GUARD]));
    d4_r.y  <= prc_pkg::XW'($signed(prod_y[63:30-prc_pkg::GUARD]));
    d4_r.z  <= z3_r;
    d4_r.cx <= cx3_r;
    d4_r.cy <= cy3_r;
  end

  assign q_valid = v4_r;
  assign q_data  = d4_r;

endmodule

>>> design/prc_cell.sv
// One CORDIC micro-rotation cell; its shift and arctangent follow from its stage index.
module prc_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [prc_pkg::SHW-1:0]       stage,
  input  logic                          d_valid,
  input  prc_pkg::cordic_t              d_data,
  output logic                          q_valid,
  output prc_pkg::cordic_t              q_data
);

  logic signed [prc_pkg::XW-1:0] xs, ys;
  logic signed [prc_pkg::ZW-1:0] atan_z;
  logic                          valid_r;
  prc_pkg::cordic_t              data_r, data_nxt;

  assign xs     = d_data.x >>> stage;
  assign ys     = d_data.y >>> stage;
  assign atan_z = {{(prc_pkg::ZW-30){1'b0}}, prc_pkg::atan_q30(stage)};

  always_comb begin
    data_nxt = d_data;
    if (!d_data.z[prc_pkg::ZW-1]) begin
      data_nxt.x = d_data.x - ys;
      data_nxt.y = d_data.y + xs;
      data_nxt.z = d_data.z - atan_z;
    end else begin
      data_nxt.x = d_data.x + ys;
      data_nxt.y = d_data.y - xs;
      data_nxt.z = d_data.z + atan_z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q_valid = valid_r;
  assign q_data  = data_r;

endmodule

>>> design/prc_post.sv
// Back end: drops the guard bits with rounding, adds the center back and saturates.
module prc_post (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          d_valid,
  input  prc_pkg::cordic_t              d_data,
  output logic                          q_valid,
  output logic signed [prc_pkg::CW-1:0] q_x,
  output logic signed [prc_pkg::CW-1:0] q_y
);

  localparam logic signed [prc_pkg::XW-1:0] HALF = prc_pkg::XW'(1) <<< (prc_pkg::GUARD - 1);

  logic signed [prc_pkg::XW-1:0] xh, yh;
  logic signed [prc_pkg::SW-1:0] sum_x, sum_y;
  logic signed [prc_pkg::CW-1:0] sat_x, sat_y;
  logic                          valid_r;
  logic signed [prc_pkg::CW-1:0] x_r, y_r;

  function automatic logic signed [prc_pkg::CW-1:0] sat(input logic signed [prc_pkg::SW-1:0] v);
    logic ovf;
    ovf = !((&v[prc_pkg::SW-1:prc_pkg::CW-1]) || !(|v[prc_pkg::SW-1:prc_pkg::CW-1]));
    if (!ovf) begin
      return v[prc_pkg::CW-1:0];
    end else if (v[prc_pkg::SW-1]) begin
      return {1'b1, {(prc_pkg::CW-1){1'b0}}};
    end else begin
      return {1'b0, {(prc_pkg::CW-1){1'b1}}};
    end
  endfunction

  assign xh    = d_data.x + HALF;
  assign yh    = d_data.y + HALF;
  assign sum_x = prc_pkg::SW'($signed(xh[prc_pkg::XW-1:prc_pkg::GUARD])) + prc_pkg::SW'(d_data.cx);
  assign sum_y = prc_pkg::SW'($signed(yh[prc_pkg::XW-1:prc_pkg::GUARD])) + prc_pkg::SW'(d_data.cy);
  assign sat_x = sat(sum_x);
  assign sat_y = sat(sum_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= sat_x;
    y_r <= sat_y;
  end

  assign q_valid = valid_r;
  assign q_x     = x_r;
  assign q_y     = y_r;

endmodule

>>> design/point_rotate_about_center.sv
// Rotates a Q16.16 point about a center by a Q3.12 angle in radians: a fully pipelined
// CORDIC row that takes one point every clock cycle (busy stays low). Its pipeline is
// four front-end stages (offset, angle folding, two-stage split gain multiply), one cell per
// micro-rotation and one rounding and saturation stage. out_valid marks each result for one
// cycle and the receiver must take it then; coordinates that overflow saturate.
module point_rotate_about_center (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [prc_pkg::CW-1:0] in_point_x,
  input  logic signed [prc_pkg::CW-1:0] in_point_y,
  input  logic signed [prc_pkg::CW-1:0] in_center_x,
  input  logic signed [prc_pkg::CW-1:0] in_center_y,
  input  logic signed [prc_pkg::AW-1:0] in_angle_rad,
  output logic                          out_valid,
  output logic signed [prc_pkg::CW-1:0] out_rotated_x,
  output logic signed [prc_pkg::CW-1:0] out_rotated_y
);

  logic             acc;
  logic             vld [prc_pkg::CORDIC_STAGES+1];
  prc_pkg::cordic_t dat [prc_pkg::CORDIC_STAGES+1];

  assign busy = 1'b0;
  assign acc  = start && !busy;

  prc_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .px      (in_point_x),
    .py      (in_point_y),
    .cx      (in_center_x),
    .cy      (in_center_y),
    .ang     (in_angle_rad),
    .q_valid (vld[0]),
    .q_data  (dat[0])
  );

  for (genvar i = 0; i < prc_pkg::CORDIC_STAGES; i++) begin : g_cell
    prc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .stage   (prc_pkg::SHW'(i)),
      .d_valid (vld[i]),
      .d_data  (dat[i]),
      .q_valid (vld[i+1]),
      .q_data  (dat[i+1])
    );
  end

  prc_post u_post (
    .clk     (clk),
    .rst_n   (rst_n),
    .d_valid (vld[prc_pkg::CORDIC_STAGES]),
    .d_data  (dat[prc_pkg::CORDIC_STAGES]),
    .q_valid (out_valid),
    .q_x     (out_rotated_x),
    .q_y     (out_rotated_y)
  );

endmodule

>>> design/prc_checker.sv
// Port-level checks for the rotator, bound to the top level.
module prc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic signed [prc_pkg::CW-1:0] in_point_x,
  input logic signed [prc_pkg::CW-1:0] in_point_y,
  input logic signed [prc_pkg::CW-1:0] in_center_x,
  input logic signed [prc_pkg::CW-1:0] in_center_y,
  input logic                          out_valid,
  input logic signed [prc_pkg::CW-1:0] out_rotated_x,
  input logic signed [prc_pkg::CW-1:0] out_rotated_y
);

  // Every transfer gives a result after the fixed latency.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(prc_pkg::LATENCY) out_valid)
    else $error("missing result after transfer");

  // No result appears without a transfer at the matching earlier cycle.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, prc_pkg::LATENCY))
    else $error("result without transfer");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe after reset");

  // A point on its own center stays where it is, for any angle.
  a_center_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_point_x == in_center_x && in_point_y == in_center_y)
      |-> ##(prc_pkg::LATENCY)
      (out_rotated_x == $past(in_center_x, prc_pkg::LATENCY) &&
       out_rotated_y == $past(in_center_y, prc_pkg::LATENCY)))
    else $error("center point moved");

endmodule

bind point_rotate_about_center prc_checker u_prc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_point_x    (in_point_x),
  .in_point_y    (in_point_y),
  .in_center_x   (in_center_x),
  .in_center_y   (in_center_y),
  .out_valid     (out_valid),
  .out_rotated_x (out_rotated_x),
  .out_rotated_y (out_rotated_y)
);
